// ===== rtl/core/aqfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Air quality fan controller package
// Shared types, event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package aqfc_pkg;

    localparam int unsigned READING_W  = 16;
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = 3;

    // Event codes carried in the command field.
    localparam logic [2:0] CMD_PM25  = 3'd0;
    localparam logic [2:0] CMD_ENV   = 3'd1;
    localparam logic [2:0] CMD_WIFI  = 3'd2;
    localparam logic [2:0] CMD_MODE  = 3'd3;
    localparam logic [2:0] CMD_LEVEL = 3'd4;
    localparam logic [2:0] CMD_POWER = 3'd5;

    // Operating modes.
    localparam logic [1:0] AUTO_MODE   = 2'd0;
    localparam logic [1:0] MANUAL_MODE = 2'd1;
    localparam logic [1:0] NIGHT_MODE  = 2'd2;

    // Fan levels.
    localparam logic [1:0] LEVEL_OFF  = 2'd0;
    localparam logic [1:0] LEVEL_LOW  = 2'd1;
    localparam logic [1:0] LEVEL_MID  = 2'd2;
    localparam logic [1:0] LEVEL_HIGH = 2'd3;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_PM25_LOW    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PM25_MID    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PM25_ALARM  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TVOC_BOOST  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TVOC_ALARM  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TVOC_MAX    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ECO2_BOOST  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_FILTER_HRS  = 3'd7;

    // Reset values.
    localparam logic [READING_W-1:0] RST_PM25_LOW   = 16'd75;
    localparam logic [READING_W-1:0] RST_PM25_MID   = 16'd115;
    localparam logic [READING_W-1:0] RST_PM25_ALARM = 16'd150;
    localparam logic [READING_W-1:0] RST_TVOC_BOOST = 16'd500;
    localparam logic [READING_W-1:0] RST_TVOC_ALARM = 16'd1000;
    localparam logic [READING_W-1:0] RST_TVOC_MAX   = 16'd2000;
    localparam logic [READING_W-1:0] RST_ECO2_BOOST = 16'd1000;
    localparam logic [READING_W-1:0] RST_FILTER_HRS = 16'd0;
    localparam logic [READING_W-1:0] RST_ECO2       = 16'd400;

    // Filter usage above this many hours asks for a replacement.
    localparam logic [READING_W-1:0] FILTER_HOURS_LIMIT = 16'd300;

    typedef struct packed {
        logic [2:0]           command;
        logic [READING_W-1:0] pm25_reading;
        logic [READING_W-1:0] tvoc_reading;
        logic [READING_W-1:0] eco2_reading;
        logic                 link_up;
        logic [1:0]           mode_request;
        logic [1:0]           fan_level_request;
    } t_in_item;

    typedef struct packed {
        logic [1:0] fan_drive_level;
        logic       fan_on;
        logic       pollution_alert;
        logic       filter_alert;
        logic       any_warning;
        logic       manual_active;
        logic       night_active;
        logic       link_status;
        logic [1:0] current_mode;
    } t_out_item;

    typedef struct packed {
        logic [READING_W-1:0] pm25_low_limit;
        logic [READING_W-1:0] pm25_mid_limit;
        logic [READING_W-1:0] pm25_alarm_limit;
        logic [READING_W-1:0] tvoc_boost_limit;
        logic [READING_W-1:0] tvoc_alarm_limit;
        logic [READING_W-1:0] tvoc_max_limit;
        logic [READING_W-1:0] eco2_boost_limit;
        logic [READING_W-1:0] filter_hours_used;
    } t_cfg;

    typedef struct packed {
        logic [1:0]           mode;
        logic [1:0]           fan_level;
        logic                 power_on;
        logic                 wifi;
        logic [READING_W-1:0] pm25;
        logic [READING_W-1:0] tvoc;
        logic [READING_W-1:0] eco2;
    } t_ctrl_state;

endpackage

// ===== rtl/core/air_quality_fan_mode_controller.sv =====
// ----------------------------------------------------------------------------
// Air quality fan mode controller
// Event driven fan mode and alert logic with an APB register file.
// ----------------------------------------------------------------------------
// Each result is registered in the main result register, or in the skid
// entry if that register stalls. One event per cycle while the skid is free.
// A two-entry output buffer keeps events flowing for one stalled result.
// Reset (synchronous, active low) restores the default limits, auto mode,
// fan level off, power on, link down and the default readings.
module air_quality_fan_mode_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Event channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  aqfc_pkg::t_in_item                  i_in_data,
    // Status channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output aqfc_pkg::t_out_item                 o_out_data,
    // Register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aqfc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [aqfc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [aqfc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    // Register file. Every register is 16 bits wide and sits at a word
    // address, so the index is simply the word offset in paddr.
    aqfc_pkg::t_cfg                      r_cfg;
    logic [aqfc_pkg::REG_IDX_W-1:0]      reg_idx;
    logic                                cfg_write;

    // Controller state, updated once per accepted event.
    aqfc_pkg::t_ctrl_state               r_state;
    aqfc_pkg::t_ctrl_state               n_state;
    aqfc_pkg::t_out_item                 result;

    // Output buffer: the main result register plus one skid entry.
    logic                                r_out_valid;
    aqfc_pkg::t_out_item                 r_out_data;
    logic                                r_skid_valid;
    aqfc_pkg::t_out_item                 r_skid_data;

    logic                                in_xfer;
    logic                                out_free;

    assign reg_idx   = paddr[aqfc_pkg::APB_ADDR_W-1:2];
    assign cfg_write = psel & penable & pwrite;
    assign pready    = 1'b1;

    always_comb begin
        unique case (reg_idx)
            aqfc_pkg::REG_PM25_LOW:   prdata = {16'd0, r_cfg.pm25_low_limit};
            aqfc_pkg::REG_PM25_MID:   prdata = {16'd0, r_cfg.pm25_mid_limit};
            aqfc_pkg::REG_PM25_ALARM: prdata = {16'd0, r_cfg.pm25_alarm_limit};
            aqfc_pkg::REG_TVOC_BOOST: prdata = {16'd0, r_cfg.tvoc_boost_limit};
            aqfc_pkg::REG_TVOC_ALARM: prdata = {16'd0, r_cfg.tvoc_alarm_limit};
            aqfc_pkg::REG_TVOC_MAX:   prdata = {16'd0, r_cfg.tvoc_max_limit};
            aqfc_pkg::REG_ECO2_BOOST: prdata = {16'd0, r_cfg.eco2_boost_limit};
            aqfc_pkg::REG_FILTER_HRS: prdata = {16'd0, r_cfg.filter_hours_used};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pm25_low_limit    <= aqfc_pkg::RST_PM25_LOW;
            r_cfg.pm25_mid_limit    <= aqfc_pkg::RST_PM25_MID;
            r_cfg.pm25_alarm_limit  <= aqfc_pkg::RST_PM25_ALARM;
            r_cfg.tvoc_boost_limit  <= aqfc_pkg::RST_TVOC_BOOST;
            r_cfg.tvoc_alarm_limit  <= aqfc_pkg::RST_TVOC_ALARM;
            r_cfg.tvoc_max_limit    <= aqfc_pkg::RST_TVOC_MAX;
            r_cfg.eco2_boost_limit  <= aqfc_pkg::RST_ECO2_BOOST;
            r_cfg.filter_hours_used <= aqfc_pkg::RST_FILTER_HRS;
        end else if (cfg_write) begin
            unique case (reg_idx)
                aqfc_pkg::REG_PM25_LOW:   r_cfg.pm25_low_limit    <= pwdata[15:0];
                aqfc_pkg::REG_PM25_MID:   r_cfg.pm25_mid_limit    <= pwdata[15:0];
                aqfc_pkg::REG_PM25_ALARM: r_cfg.pm25_alarm_limit  <= pwdata[15:0];
                aqfc_pkg::REG_TVOC_BOOST: r_cfg.tvoc_boost_limit  <= pwdata[15:0];
                aqfc_pkg::REG_TVOC_ALARM: r_cfg.tvoc_alarm_limit  <= pwdata[15:0];
                aqfc_pkg::REG_TVOC_MAX:   r_cfg.tvoc_max_limit    <= pwdata[15:0];
                aqfc_pkg::REG_ECO2_BOOST: r_cfg.eco2_boost_limit  <= pwdata[15:0];
                aqfc_pkg::REG_FILTER_HRS: r_cfg.filter_hours_used <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // The evaluation is purely combinational from the held state and the
    // incoming event; its next state and result are captured together.
    aqfc_eval u_eval (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (i_in_data),
        .o_state  (n_state),
        .o_result (result)
    );

    // Events are taken whenever the skid entry is free. With the main
    // result register stalled, the next result lands in the skid entry,
    // which then holds off further transfers until it drains.
    assign o_in_ready = ~r_skid_valid;
    assign in_xfer    = i_in_valid & o_in_ready;
    assign out_free   = ~r_out_valid | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode      <= aqfc_pkg::AUTO_MODE;
            r_state.fan_level <= aqfc_pkg::LEVEL_OFF;
            r_state.power_on  <= 1'b1;
            r_state.wifi      <= 1'b0;
            r_state.pm25      <= '0;
            r_state.tvoc      <= '0;
            r_state.eco2      <= aqfc_pkg::RST_ECO2;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_xfer;
                if (in_xfer) begin
                    r_out_data <= result;
                end
            end
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
            r_skid_data  <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/core/aqfc_eval.sv =====
// ----------------------------------------------------------------------------
// Air quality fan controller event evaluation
// Applies one event to the controller state and derives the status result.
// ----------------------------------------------------------------------------
module aqfc_eval (
    input  aqfc_pkg::t_ctrl_state i_state,
    input  aqfc_pkg::t_cfg        i_cfg,
    input  aqfc_pkg::t_in_item    i_item,
    output aqfc_pkg::t_ctrl_state o_state,
    output aqfc_pkg::t_out_item   o_result
);

    aqfc_pkg::t_ctrl_state upd;
    logic [1:0]            pm25_level;
    logic [1:0]            auto_level;
    logic                  boost;
    logic                  force_high;
    logic                  pollution;
    logic                  filter_due;
    logic [1:0]            drive;

    // Event decode: only the fields that belong to the event are taken.
    always_comb begin
        upd = i_state;
        unique case (i_item.command)
            aqfc_pkg::CMD_PM25: begin
                upd.pm25 = i_item.pm25_reading;
            end
            aqfc_pkg::CMD_ENV: begin
                upd.tvoc = i_item.tvoc_reading;
                upd.eco2 = i_item.eco2_reading;
            end
            aqfc_pkg::CMD_WIFI: begin
                upd.wifi = i_item.link_up;
            end
            aqfc_pkg::CMD_MODE: begin
                if (i_item.mode_request == aqfc_pkg::AUTO_MODE ||
                    i_item.mode_request == aqfc_pkg::MANUAL_MODE ||
                    i_item.mode_request == aqfc_pkg::NIGHT_MODE) begin
                    upd.mode = i_item.mode_request;
                end
            end
            aqfc_pkg::CMD_LEVEL: begin
                if (i_state.mode == aqfc_pkg::MANUAL_MODE) begin
                    upd.fan_level = i_item.fan_level_request;
                end
            end
            aqfc_pkg::CMD_POWER: begin
                upd.power_on = ~i_state.power_on;
            end
            default: begin
            end
        endcase
    end

    // Threshold evaluation on the updated readings.
    always_comb begin
        if (upd.pm25 <= i_cfg.pm25_low_limit) begin
            pm25_level = aqfc_pkg::LEVEL_LOW;
        end else if (upd.pm25 <= i_cfg.pm25_mid_limit) begin
            pm25_level = aqfc_pkg::LEVEL_MID;
        end else begin
            pm25_level = aqfc_pkg::LEVEL_HIGH;
        end
        boost      = (upd.tvoc > i_cfg.tvoc_boost_limit) || (upd.eco2 > i_cfg.eco2_boost_limit);
        force_high = (upd.pm25 > i_cfg.pm25_alarm_limit) || (upd.tvoc > i_cfg.tvoc_max_limit);
        if (force_high) begin
            auto_level = aqfc_pkg::LEVEL_HIGH;
        end else if (boost && pm25_level == aqfc_pkg::LEVEL_LOW) begin
            auto_level = aqfc_pkg::LEVEL_MID;
        end else begin
            auto_level = pm25_level;
        end
        pollution  = (upd.pm25 > i_cfg.pm25_alarm_limit) ||
                     (upd.tvoc > i_cfg.tvoc_alarm_limit);
        filter_due = i_cfg.filter_hours_used > aqfc_pkg::FILTER_HOURS_LIMIT;
    end

    always_comb begin
        o_state = upd;
        if (upd.mode == aqfc_pkg::NIGHT_MODE) begin
            o_state.fan_level = aqfc_pkg::LEVEL_LOW;
        end else if (upd.mode != aqfc_pkg::MANUAL_MODE) begin
            o_state.fan_level = auto_level;
        end
        drive = o_state.power_on ? o_state.fan_level : aqfc_pkg::LEVEL_OFF;

        o_result.fan_drive_level = drive;
        o_result.fan_on          = drive != aqfc_pkg::LEVEL_OFF;
        o_result.pollution_alert = pollution;
        o_result.filter_alert    = filter_due;
        o_result.any_warning     = pollution | filter_due;
        o_result.manual_active   = upd.mode == aqfc_pkg::MANUAL_MODE;
        o_result.night_active    = upd.mode == aqfc_pkg::NIGHT_MODE;
        o_result.link_status     = upd.wifi;
        o_result.current_mode    = upd.mode;
    end

endmodule

// ===== rtl/core/aqfc_checker.sv =====
// ----------------------------------------------------------------------------
// Air quality fan controller checker
// Port-level properties of the status channel, bound to the top level.
// ----------------------------------------------------------------------------
module aqfc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input aqfc_pkg::t_out_item o_out_data
);

    // A stalled result holds until it is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
    else $error("stalled status transfer changed");

    // The running flag and the warning summary follow the other fields.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.fan_on ==
                         (o_out_data.fan_drive_level != aqfc_pkg::LEVEL_OFF)) &&
                        (o_out_data.any_warning ==
                         (o_out_data.pollution_alert | o_out_data.filter_alert)))
    else $error("status summary bits disagree with fields");

    // Mode flags match the reported mode, which is never the unused code.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.current_mode <= aqfc_pkg::NIGHT_MODE) &&
                        (o_out_data.manual_active ==
                         (o_out_data.current_mode == aqfc_pkg::MANUAL_MODE)) &&
                        (o_out_data.night_active ==
                         (o_out_data.current_mode == aqfc_pkg::NIGHT_MODE)))
    else $error("mode flags disagree with current mode");

    // Night mode drives the fan at low speed or not at all.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.night_active |->
            (o_out_data.fan_drive_level == aqfc_pkg::LEVEL_OFF) ||
            (o_out_data.fan_drive_level == aqfc_pkg::LEVEL_LOW))
    else $error("night mode drive level above low");

endmodule

bind air_quality_fan_mode_controller aqfc_checker u_aqfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== tb/sv/aqfc_status_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fan controller status checker
// Watches the event, status and register channels. It keeps its own copy
// of the controller state, predicts one status per event and compares each
// status transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module aqfc_status_checker
    import aqfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic                  i_pready,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int REPORT_LIMIT = 10;

    t_cfg                 limits;
    logic [1:0]           mode_now;
    logic [1:0]           level_now;
    logic                 power_on;
    logic                 link_now;
    logic [READING_W-1:0] pm25_now;
    logic [READING_W-1:0] tvoc_now;
    logic [READING_W-1:0] eco2_now;

    t_out_item            status_due[$];
    t_out_item            want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Applies one event to the local state and returns the status it gives.
    function automatic t_out_item next_status(input t_in_item ev);
        t_out_item  st;
        logic [1:0] lvl;
        logic       polluted;
        logic       filter_due;
        case (ev.command)
            CMD_PM25:  pm25_now = ev.pm25_reading;
            CMD_ENV: begin
                tvoc_now = ev.tvoc_reading;
                eco2_now = ev.eco2_reading;
            end
            CMD_WIFI:  link_now = ev.link_up;
            CMD_MODE:  if (ev.mode_request <= NIGHT_MODE) mode_now = ev.mode_request;
            CMD_LEVEL: if (mode_now == MANUAL_MODE) level_now = ev.fan_level_request;
            CMD_POWER: power_on = ~power_on;
            default: ;
        endcase

        polluted   = (pm25_now > limits.pm25_alarm_limit) ||
                     (tvoc_now > limits.tvoc_alarm_limit);
        filter_due = limits.filter_hours_used > FILTER_HOURS_LIMIT;

        if (mode_now == NIGHT_MODE) begin
            level_now = LEVEL_LOW;
        end else if (mode_now != MANUAL_MODE) begin
            if (pm25_now <= limits.pm25_low_limit)      lvl = LEVEL_LOW;
            else if (pm25_now <= limits.pm25_mid_limit) lvl = LEVEL_MID;
            else                                        lvl = LEVEL_HIGH;
            if (tvoc_now > limits.tvoc_boost_limit && lvl < LEVEL_MID) lvl = LEVEL_MID;
            if (eco2_now > limits.eco2_boost_limit && lvl < LEVEL_MID) lvl = LEVEL_MID;
            if (pm25_now > limits.pm25_alarm_limit || tvoc_now > limits.tvoc_max_limit)
                lvl = LEVEL_HIGH;
            level_now = lvl;
        end

        st.fan_drive_level = power_on ? level_now : LEVEL_OFF;
        st.fan_on          = st.fan_drive_level != LEVEL_OFF;
        st.pollution_alert = polluted;
        st.filter_alert    = filter_due;
        st.any_warning     = polluted | filter_due;
        st.manual_active   = mode_now == MANUAL_MODE;
        st.night_active    = mode_now == NIGHT_MODE;
        st.link_status     = link_now;
        st.current_mode    = mode_now;
        return st;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limits    = '{RST_PM25_LOW, RST_PM25_MID, RST_PM25_ALARM, RST_TVOC_BOOST,
                          RST_TVOC_ALARM, RST_TVOC_MAX, RST_ECO2_BOOST, RST_FILTER_HRS};
            mode_now  = AUTO_MODE;
            level_now = LEVEL_OFF;
            power_on  = 1'b1;
            link_now  = 1'b0;
            pm25_now  = '0;
            tvoc_now  = '0;
            eco2_now  = RST_ECO2;
            status_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[APB_ADDR_W-1:2])
                    REG_PM25_LOW:   limits.pm25_low_limit    = i_pwdata[READING_W-1:0];
                    REG_PM25_MID:   limits.pm25_mid_limit    = i_pwdata[READING_W-1:0];
                    REG_PM25_ALARM: limits.pm25_alarm_limit  = i_pwdata[READING_W-1:0];
                    REG_TVOC_BOOST: limits.tvoc_boost_limit  = i_pwdata[READING_W-1:0];
                    REG_TVOC_ALARM: limits.tvoc_alarm_limit  = i_pwdata[READING_W-1:0];
                    REG_TVOC_MAX:   limits.tvoc_max_limit    = i_pwdata[READING_W-1:0];
                    REG_ECO2_BOOST: limits.eco2_boost_limit  = i_pwdata[READING_W-1:0];
                    REG_FILTER_HRS: limits.filter_hours_used = i_pwdata[READING_W-1:0];
                    default: ;
                endcase
            end

            // The status of an event shows up in the cycle after its transfer at
            // the earliest, so the comparison runs before the new prediction.
            if (i_out_valid && i_out_ready) begin
                if (status_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT)
                        $display("%0t: status transfer with no event pending, got %h",
                                 $time, i_out_data);
                end else begin
                    want = status_due.pop_front();
                    if (i_out_data !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT)
                            $display("%0t: status mismatch, expected %h actual %h",
                                     $time, want, i_out_data);
                    end
                end
            end

            if (i_in_valid && i_in_ready)
                status_due.push_back(next_status(i_in_data));
        end
        o_pending = status_due.size();
    end

endmodule

// ===== tb/sv/tb_air_quality_fan_mode_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Air quality fan mode controller testbench
// Drives directed and random events through the controller under several
// threshold settings and idle patterns, with a long status hold-off, while
// a separate checker predicts and compares every status transfer.
// ----------------------------------------------------------------------------
module tb_air_quality_fan_mode_controller;
    import aqfc_pkg::*;

    localparam int          PHASE_COUNT      = 6;
    localparam int          EVENTS_PER_PHASE = 125;
    localparam int          HOLD_OFF_CYCLES  = 300;
    localparam int          SETTLE_CYCLES    = 4;
    localparam int          WATCHDOG_LIMIT   = 2000;
    // Mode request code that names no mode; the controller must ignore it.
    localparam logic [1:0]  MODE_BOGUS       = 2'd3;

    // All inputs of the block are given known values from time zero.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    fail_count;
    int                    pending_count;

    // Idle pattern of the current phase, in percent of cycles.
    int unsigned           tx_idle_pct  = 0;
    int unsigned           rx_stall_pct = 0;
    // Set by the stimulus to ask the status receiver for a long hold-off.
    logic                  hold_off_req = 1'b0;
    // Thresholds as last written; the stimulus aims readings around them.
    t_cfg                  limits_set;
    int                    idle_cycles  = 0;

    air_quality_fan_mode_controller dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    aqfc_status_checker u_status_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending_count)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Status receiver. It normally stalls at the phase's rate; on request it
    // holds off for a long stretch so the output buffer fills and the event
    // channel has to stall as well.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Watchdog: the run ends if no transfer happens on either channel for
    // too long. Register writes and the final pause are far shorter.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL air_quality_fan_mode_controller");
                $finish;
            end
        end
    end

    // Builds an event; the fields that the command does not use stay random.
    // For the wifi, mode and level commands the low bits of a carry the value.
    function automatic t_in_item event_of(input logic [2:0] cmd, input logic [15:0] a,
                                          input logic [15:0] b);
        t_in_item ev;
        ev.command           = cmd;
        ev.pm25_reading      = 16'($urandom);
        ev.tvoc_reading      = 16'($urandom);
        ev.eco2_reading      = 16'($urandom);
        ev.link_up           = 1'($urandom);
        ev.mode_request      = 2'($urandom);
        ev.fan_level_request = 2'($urandom);
        case (cmd)
            CMD_PM25: ev.pm25_reading = a;
            CMD_ENV: begin
                ev.tvoc_reading = a;
                ev.eco2_reading = b;
            end
            CMD_WIFI:  ev.link_up           = a[0];
            CMD_MODE:  ev.mode_request      = a[1:0];
            CMD_LEVEL: ev.fan_level_request = a[1:0];
            default: ;
        endcase
        return ev;
    endfunction

    // Readings cluster around the current thresholds, since the decisions
    // flip there, with the extremes and plain random values mixed in.
    function automatic logic [15:0] pick_reading();
        logic [15:0] anchor;
        int          v;
        case ($urandom_range(7))
            0:       anchor = limits_set.pm25_low_limit;
            1:       anchor = limits_set.pm25_mid_limit;
            2:       anchor = limits_set.pm25_alarm_limit;
            3:       anchor = limits_set.tvoc_boost_limit;
            4:       anchor = limits_set.tvoc_alarm_limit;
            5:       anchor = limits_set.tvoc_max_limit;
            6:       anchor = limits_set.eco2_boost_limit;
            default: anchor = RST_ECO2;
        endcase
        case ($urandom_range(9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: begin
                v = int'(anchor) + int'($urandom_range(8)) - 4;
                if (v < 0)     v = 0;
                if (v > 65535) v = 65535;
                return 16'(v);
            end
            6, 7:       return 16'($urandom_range(400));
            default:    return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_event();
        int unsigned pick;
        logic [2:0]  cmd;
        pick = $urandom_range(99);
        if (pick < 30)      cmd = CMD_PM25;
        else if (pick < 50) cmd = CMD_ENV;
        else if (pick < 58) cmd = CMD_WIFI;
        else if (pick < 72) cmd = CMD_MODE;
        else if (pick < 88) cmd = CMD_LEVEL;
        else if (pick < 96) cmd = CMD_POWER;
        else                cmd = CMD_POWER + 3'($urandom_range(1, 2));  // unused codes
        return event_of(cmd, pick_reading(), pick_reading());
    endfunction

    // Offers one event and returns at the falling edge after its transfer,
    // with valid still high so a following event can go out back to back.
    task automatic send_event(input t_in_item ev);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Lowers valid and waits until every predicted status has been taken.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One register write: setup cycle, then access cycle until pready.
    // psel is left high; the caller lowers it after the last write.
    task automatic write_limit(input logic [REG_IDX_W-1:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
    endtask

    task automatic load_limits(input t_cfg cfg);
        limits_set = cfg;
        write_limit(REG_PM25_LOW,   cfg.pm25_low_limit);
        write_limit(REG_PM25_MID,   cfg.pm25_mid_limit);
        write_limit(REG_PM25_ALARM, cfg.pm25_alarm_limit);
        write_limit(REG_TVOC_BOOST, cfg.tvoc_boost_limit);
        write_limit(REG_TVOC_ALARM, cfg.tvoc_alarm_limit);
        write_limit(REG_TVOC_MAX,   cfg.tvoc_max_limit);
        write_limit(REG_ECO2_BOOST, cfg.eco2_boost_limit);
        write_limit(REG_FILTER_HRS, cfg.filter_hours_used);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        t_cfg cfg;
        int   phase;

        limits_set = '{RST_PM25_LOW, RST_PM25_MID, RST_PM25_ALARM, RST_TVOC_BOOST,
                       RST_TVOC_ALARM, RST_TVOC_MAX, RST_ECO2_BOOST, RST_FILTER_HRS};

        // Reset is held from time zero and released at a falling edge.
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed events with the reset thresholds: each auto level band
        // and its boundaries, the readings at their extremes, the link flag,
        // a level command outside manual mode, entering manual mode (the last
        // computed level is kept), an unknown mode request, night mode, both
        // power toggles and the two unused command codes.
        send_event(event_of(CMD_PM25,  16'd0,     16'd0));
        send_event(event_of(CMD_PM25,  16'd76,    16'd0));
        send_event(event_of(CMD_PM25,  16'd116,   16'd0));
        send_event(event_of(CMD_PM25,  16'd150,   16'd0));
        send_event(event_of(CMD_PM25,  16'd151,   16'd0));
        send_event(event_of(CMD_PM25,  16'd65535, 16'd0));
        send_event(event_of(CMD_PM25,  16'd10,    16'd0));
        send_event(event_of(CMD_ENV,   16'd501,   16'd400));
        send_event(event_of(CMD_ENV,   16'd0,     16'd1001));
        send_event(event_of(CMD_ENV,   16'd1001,  16'd0));
        send_event(event_of(CMD_ENV,   16'd2001,  16'd65535));
        send_event(event_of(CMD_ENV,   16'd65535, 16'd65535));
        send_event(event_of(CMD_WIFI,  16'd1,     16'd0));
        send_event(event_of(CMD_WIFI,  16'd0,     16'd0));
        send_event(event_of(CMD_LEVEL, 16'(LEVEL_LOW),   16'd0));
        send_event(event_of(CMD_MODE,  16'(MANUAL_MODE), 16'd0));
        send_event(event_of(CMD_LEVEL, 16'(LEVEL_HIGH),  16'd0));
        send_event(event_of(CMD_LEVEL, 16'(LEVEL_OFF),   16'd0));
        send_event(event_of(CMD_MODE,  16'(MODE_BOGUS),  16'd0));
        send_event(event_of(CMD_LEVEL, 16'(LEVEL_MID),   16'd0));
        send_event(event_of(CMD_MODE,  16'(NIGHT_MODE),  16'd0));
        send_event(event_of(CMD_POWER, 16'd0,     16'd0));
        send_event(event_of(CMD_POWER + 3'd1, 16'd0, 16'd0));
        send_event(event_of(CMD_POWER + 3'd2, 16'd0, 16'd0));
        send_event(event_of(CMD_POWER, 16'd0,     16'd0));
        send_event(event_of(CMD_MODE,  16'(AUTO_MODE),   16'd0));

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            // Thresholds only change while nothing is in flight.
            settle_idle();
            case (phase)
                1: cfg = '0;
                2: cfg = '1;
                4: begin
                    cfg = '{RST_PM25_LOW, RST_PM25_MID, RST_PM25_ALARM, RST_TVOC_BOOST,
                            RST_TVOC_ALARM, RST_TVOC_MAX, RST_ECO2_BOOST, RST_FILTER_HRS};
                    cfg.filter_hours_used = FILTER_HOURS_LIMIT + 16'd1;
                end
                5: begin
                    cfg = '{RST_PM25_LOW, RST_PM25_MID, RST_PM25_ALARM, RST_TVOC_BOOST,
                            RST_TVOC_ALARM, RST_TVOC_MAX, RST_ECO2_BOOST, RST_FILTER_HRS};
                    cfg.filter_hours_used = FILTER_HOURS_LIMIT;
                end
                3: cfg = t_cfg'({$urandom, $urandom, $urandom, $urandom});
                default: begin
                    // Ordered limits, so every auto band is reachable.
                    cfg.pm25_low_limit    = 16'($urandom_range(1000));
                    cfg.pm25_mid_limit    = cfg.pm25_low_limit + 16'($urandom_range(500));
                    cfg.pm25_alarm_limit  = cfg.pm25_mid_limit + 16'($urandom_range(500));
                    cfg.tvoc_boost_limit  = 16'($urandom_range(3000));
                    cfg.tvoc_alarm_limit  = cfg.tvoc_boost_limit + 16'($urandom_range(1000));
                    cfg.tvoc_max_limit    = cfg.tvoc_alarm_limit + 16'($urandom_range(1000));
                    cfg.eco2_boost_limit  = 16'($urandom_range(3000));
                    cfg.filter_hours_used = 16'($urandom_range(250, 350));
                end
            endcase
            load_limits(cfg);

            // Idle patterns rotate: none, sender idle, receiver stalls, both.
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 69; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 69; end
                default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
            endcase
            // The sender keeps offering events through the long hold-off.
            if (phase == 4) hold_off_req = 1'b1;

            repeat (EVENTS_PER_PHASE) send_event(random_event());
        end

        settle_idle();
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS air_quality_fan_mode_controller");
        end else begin
            $display("FAIL air_quality_fan_mode_controller");
        end
        $finish;
    end

endmodule
